// ===== hw/rtl/psrmse_pkg.sv =====
// Shared types and constants for the per-slice rmse accumulator.
// No dependencies; imported by per_slice_rmse_accumulator and the testbench.
package psrmse_pkg;

  // fixed field and datapath widths
  localparam int SIZE_W    = 9;   // size registers and position counters
  localparam int SLICE_W   = 8;   // slice_index / slice_number
  localparam int SUM_W     = 48;  // per-slice sum of squares
  localparam int FRAC_W    = 16;  // fraction bits added before the divide
  localparam int QUO_W     = SUM_W + FRAC_W;
  localparam int CNT_W     = 2 * SIZE_W;  // samples per slice, up to 511*511
  localparam int ROOT_W    = QUO_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int RMSE_W    = 24;
  localparam int STEP_W    = $clog2(QUO_W);
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;

  // command codes
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // read status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_INCOMPLETE = 2'd1,
    STAT_EXCESS     = 2'd2,
    STAT_RANGE      = 2'd3
  } status_t;

  // slicing axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_AXIS   = 2'd0,
    REG_SIZE_X = 2'd1,
    REG_SIZE_Y = 2'd2,
    REG_SIZE_Z = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD_WAIT,
    ST_RD_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  // a size of zero counts as one, a size above the array depth as the depth
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                 input int unsigned max_dim);
    logic [SIZE_W-1:0] r;
    r = raw;
    if (raw == '0) begin
      r = SIZE_W'(1);
    end else if (32'(raw) > max_dim) begin
      r = SIZE_W'(max_dim);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/per_slice_rmse_accumulator.sv =====
// Per-slice rms error accumulator: sum-of-squares memory, sample pipeline,
// serial divider and serial square root. Depends on psrmse_pkg.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  command   | start, busy            | cmd, sample_a, sample_b, slice_index
//  result    | done (one-cycle pulse) | rmse_value, slice_number, status
//  config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// Sample items enter one per cycle while the block is idle; each does a read-modify-write
// of its slice sum with forwarding from the two writes still in flight.
// A read item waits for the sample pipeline to drain, reads its slice sum from memory,
// runs the bit-serial divide and then the bit-serial root, then one done cycle.
// A read outside the axis goes straight to the done cycle.
// Reset and the clear command sweep the sum memory with busy high.
// The result side cannot stall; config is always ready.
module per_slice_rmse_accumulator #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic signed [SAMPLE_BITS-1:0]       sample_a,
  input  logic signed [SAMPLE_BITS-1:0]       sample_b,
  input  logic [psrmse_pkg::SLICE_W-1:0]      slice_index,
  output logic                                done,
  output logic [psrmse_pkg::RMSE_W-1:0]       rmse_value,
  output logic [psrmse_pkg::SLICE_W-1:0]      slice_number,
  output logic [1:0]                          status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [psrmse_pkg::SIZE_W-1:0]       cfg_data
);
  import psrmse_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DIF_W = SAMPLE_BITS + 1;
  localparam int SQ_W  = 2 * DIF_W;
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_DIM - 1);

  // configuration
  logic [1:0]        slice_axis;
  logic [SIZE_W-1:0] size_x, size_y, size_z;

  // sequencer and position state
  state_t            state, state_next;
  logic [SIZE_W-1:0] pos_x, pos_y, pos_z;
  logic              excess_seen;
  logic [IDX_W-1:0]  sweep;
  logic [STEP_W-1:0] step;

  // sum memory
  logic [SUM_W-1:0]  sums [MAX_DIM];
  logic [SUM_W-1:0]  rd_data;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  logic [SUM_W-1:0]  mem_wdata;
  logic              mem_we;

  // sample pipeline
  logic                          p1_valid, p2_valid, w1_valid;
  logic [IDX_W-1:0]              p1_addr, p2_addr, w1_addr;
  logic signed [SAMPLE_BITS-1:0] p1_a, p1_b;
  logic [SUM_W-1:0]              p2_sq, p2_old, w1_data;
  logic [SUM_W-1:0]              new_sum;
  logic signed [DIF_W-1:0]       diff;
  logic [DIF_W-1:0]              mag;
  logic [SQ_W-1:0]               sq;
  logic [SUM_W-1:0]              fwd_old;

  // read arithmetic
  logic [CNT_W-1:0]  count;
  logic [QUO_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    div_trial;
  logic              div_take;
  logic [ROOT_W-1:0] root, root_next;
  logic [SREM_W-1:0] srem, srem_next;
  logic [SREM_W+1:0] sq_cur, sq_trial;

  // derived controls
  logic              accept, take_sample, rd_range_bad;
  logic [SIZE_W-1:0] sx, sy, sz, n_axis, cnt_a, cnt_b;
  logic [1:0]        axis;
  logic [SIZE_W-1:0] pos_sel;

  assign cfg_ready = 1'b1;

  // effective sizes and axis
  always_comb begin
    sx = eff_size(size_x, MAX_DIM);
    sy = eff_size(size_y, MAX_DIM);
    sz = eff_size(size_z, MAX_DIM);
    axis = (slice_axis == AXIS_Y || slice_axis == AXIS_Z) ? slice_axis : AXIS_X;
    n_axis = sx;
    cnt_a = sy;
    cnt_b = sz;
    pos_sel = pos_x;
    if (axis == AXIS_Y) begin
      n_axis = sy;
      cnt_a = sx;
      cnt_b = sz;
      pos_sel = pos_y;
    end else if (axis == AXIS_Z) begin
      n_axis = sz;
      cnt_a = sx;
      cnt_b = sy;
      pos_sel = pos_z;
    end
    rd_range_bad = ({1'b0, slice_index} >= n_axis) || (32'(slice_index) >= MAX_DIM);
  end

  assign accept      = start && !busy;
  assign take_sample = accept && (cmd == CMD_SAMPLE) && (pos_z < sz);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_READ) begin
            state_next = rd_range_bad ? ST_DONE : ST_RD_WAIT;
          end else if (cmd == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR:   if (sweep == LAST_ENTRY) state_next = ST_IDLE;
      ST_RD_WAIT: if (!p1_valid && !p2_valid) state_next = ST_RD_LOAD;
      ST_RD_LOAD: state_next = ST_DIV;
      ST_DIV:     if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_SQRT;
      ST_SQRT:    if (step == STEP_W'(SQRT_STEPS - 1)) state_next = ST_DONE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
  end

  // memory port selection
  always_comb begin
    mem_raddr = (state == ST_IDLE) ? IDX_W'(pos_sel) : IDX_W'(slice_number);
    mem_we    = (state == ST_CLEAR) || p2_valid;
    mem_waddr = (state == ST_CLEAR) ? sweep : p2_addr;
    mem_wdata = (state == ST_CLEAR) ? '0 : new_sum;
  end

  // sum memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= sums[mem_raddr];
  end

  // squared difference and forwarding of sums still being written
  always_comb begin
    diff = DIF_W'(p1_a) - DIF_W'(p1_b);
    mag  = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
    sq   = SQ_W'(mag) * SQ_W'(mag);
    new_sum = p2_old + p2_sq;
    priority if (p2_valid && p2_addr == p1_addr) begin
      fwd_old = new_sum;
    end else if (w1_valid && w1_addr == p1_addr) begin
      fwd_old = w1_data;
    end else begin
      fwd_old = rd_data;
    end
  end

  // one divide step and one root step
  always_comb begin
    div_trial = {rem, dq[QUO_W-1]};
    div_take  = (div_trial >= {1'b0, count});
    sq_cur    = {srem, dq[QUO_W-1 -: 2]};
    sq_trial  = (SREM_W + 2)'({root, 2'b01});
    if (sq_cur >= sq_trial) begin
      srem_next = SREM_W'(sq_cur - sq_trial);
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      srem_next = SREM_W'(sq_cur);
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  // sample pipeline data
  always_ff @(posedge clk) begin
    p1_addr <= IDX_W'(pos_sel);
    p1_a    <= sample_a;
    p1_b    <= sample_b;
    p2_addr <= p1_addr;
    p2_sq   <= SUM_W'(sq);
    p2_old  <= fwd_old;
    w1_addr <= p2_addr;
    w1_data <= new_sum;
  end

  // control state, configuration and read datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sweep       <= '0;
      step        <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      excess_seen <= 1'b0;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
      w1_valid    <= 1'b0;
      slice_axis  <= AXIS_X;
      size_x      <= SIZE_W'(256);
      size_y      <= SIZE_W'(256);
      size_z      <= SIZE_W'(256);
    end else begin
      state    <= state_next;
      // a clear item drops samples still in flight
      p1_valid <= take_sample;
      p2_valid <= p1_valid && !(accept && cmd == CMD_CLEAR);
      w1_valid <= p2_valid && !(accept && cmd == CMD_CLEAR);

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_AXIS:   slice_axis <= cfg_data[1:0];
          REG_SIZE_X: size_x <= cfg_data;
          REG_SIZE_Y: size_y <= cfg_data;
          REG_SIZE_Z: size_z <= cfg_data;
        endcase
      end

      // raster position walk
      if (accept && cmd == CMD_SAMPLE) begin
        if (pos_z >= sz) begin
          excess_seen <= 1'b1;
        end else if ({1'b0, pos_x} + 1'b1 >= {1'b0, sx}) begin
          pos_x <= '0;
          if ({1'b0, pos_y} + 1'b1 >= {1'b0, sy}) begin
            pos_y <= '0;
            pos_z <= pos_z + 1'b1;
          end else begin
            pos_y <= pos_y + 1'b1;
          end
        end else begin
          pos_x <= pos_x + 1'b1;
        end
      end

      // clear resets the position walk and excess flag and restarts the sweep
      if (accept && cmd == CMD_CLEAR) begin
        pos_x       <= '0;
        pos_y       <= '0;
        pos_z       <= '0;
        excess_seen <= 1'b0;
        sweep       <= '0;
      end else if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
      end

      // read item setup
      if (accept && cmd == CMD_READ) begin
        slice_number <= slice_index;
        count        <= CNT_W'(cnt_a) * CNT_W'(cnt_b);
        if (rd_range_bad) begin
          status     <= STAT_RANGE;
          rmse_value <= '0;
        end else if (excess_seen) begin
          status <= STAT_EXCESS;
        end else if (pos_z < sz) begin
          status <= STAT_INCOMPLETE;
        end else begin
          status <= STAT_OK;
        end
      end

      // divide then root, one bit a cycle
      if (state == ST_RD_LOAD) begin
        dq   <= {rd_data, FRAC_W'(0)};
        rem  <= '0;
        step <= '0;
      end else if (state == ST_DIV) begin
        rem  <= div_take ? CNT_W'(div_trial - {1'b0, count}) : CNT_W'(div_trial);
        dq   <= {dq[QUO_W-2:0], div_take};
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step <= '0;
          root <= '0;
          srem <= '0;
        end else begin
          step <= step + 1'b1;
        end
      end else if (state == ST_SQRT) begin
        root <= root_next;
        srem <= srem_next;
        dq   <= {dq[QUO_W-3:0], 2'b00};
        step <= step + 1'b1;
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          rmse_value <= (root_next[ROOT_W-1:RMSE_W] != '0) ? '1 : root_next[RMSE_W-1:0];
        end
      end
    end
  end

`ifndef SYNTHESIS
  // the sweep owns the write port: no sample write may land during it
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !p2_valid)
    else $error("sample write during clear sweep");

  // a read fetches its sum only once the pipeline has drained
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_LOAD) |-> (!p1_valid && !p2_valid && !$past(p2_valid)))
    else $error("slice read overlapped a pending sum write");

  // each result is a single-cycle strobe
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // samples enter the pipeline only from idle
  assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> $past(state == ST_IDLE))
    else $error("sample entered pipeline while busy");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for per_slice_rmse_accumulator: a directed table of items,
// then randomized volumes, all checked against a behavioral model of the slice sums.
// Depends on psrmse_pkg and the accumulator rtl.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psrmse_pkg::*;

  localparam int DEPTH        = 256;
  localparam int SAMPLE_W     = 16;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 128;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PCT     = 16;
  localparam int STREAM_CAP   = 300;
  localparam int SIZE_TOP     = (1 << SIZE_W) - 1;

  localparam logic [SAMPLE_W-1:0] S_MAX     = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] S_MIN     = 16'h8000;
  localparam logic [RMSE_W-1:0]   RMSE_SAT  = 24'hffffff;
  // full-scale difference, 65535 with 8 fraction bits
  localparam logic [RMSE_W-1:0]   RMSE_FULL = 24'hffff00;
  // unused axis code, behaves as x
  localparam logic [1:0]          AXIS_ALT  = 2'd3;

  typedef struct packed {
    logic [RMSE_W-1:0]  rmse;
    logic [SLICE_W-1:0] slice;
    status_t            st;
  } read_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          op;
    logic [SAMPLE_W-1:0] a, b;
    logic [SIZE_W-1:0]   arg;
    logic                typed;
    logic [RMSE_W-1:0]   rmse;
    status_t             st;
  } script_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 cmd = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_a = '0;
  logic signed [SAMPLE_W-1:0] sample_b = '0;
  logic [SLICE_W-1:0]         slice_index = '0;
  logic                       done;
  logic [RMSE_W-1:0]          rmse_value;
  logic [SLICE_W-1:0]         slice_number;
  logic [1:0]                 status;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = REG_AXIS;
  logic [SIZE_W-1:0]          cfg_data = '0;

  // model state
  logic [SUM_W-1:0]  slice_sum [DEPTH];
  int unsigned       at_x, at_y, at_z;
  bit                overrun;
  logic [1:0]        reg_axis;
  logic [SIZE_W-1:0] reg_sx, reg_sy, reg_sz;

  read_result_t pending_reads [$];
  script_row_t  script [$];
  int           errors = 0;
  int           items_sent = 0;
  bit           idle_on = 1'b1;
  int unsigned  cycle_count = 0;

  per_slice_rmse_accumulator #(
    .MAX_DIM    (DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (.*);

  always #CLK_HALF clk = ~clk;

  // zero size counts as one, oversize as the array depth
  function automatic int unsigned eff_extent(logic [SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > DEPTH) return DEPTH;
    return int'(raw);
  endfunction

  function automatic logic [1:0] live_axis();
    return (reg_axis == AXIS_ALT) ? AXIS_X : reg_axis;
  endfunction

  function automatic int unsigned slices_on_axis();
    case (live_axis())
      AXIS_Y: return eff_extent(reg_sy);
      AXIS_Z: return eff_extent(reg_sz);
      default: return eff_extent(reg_sx);
    endcase
  endfunction

  // bitwise floor square root, one result bit per pass
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    foreach (slice_sum[i]) slice_sum[i] = '0;
    at_x = 0;
    at_y = 0;
    at_z = 0;
    overrun = 1'b0;
  endfunction

  function automatic void write_model_reg(cfg_reg_t r, logic [SIZE_W-1:0] d);
    case (r)
      REG_AXIS:   reg_axis = d[1:0];
      REG_SIZE_X: reg_sx = d;
      REG_SIZE_Y: reg_sy = d;
      REG_SIZE_Z: reg_sz = d;
      default: ;
    endcase
  endfunction

  // applies one item to the slice sums; returns 1 with the read result for a read
  function automatic bit step_slice_sums(cmd_t c, logic [SAMPLE_W-1:0] a,
                                         logic [SAMPLE_W-1:0] b,
                                         logic [SLICE_W-1:0] si,
                                         output read_result_t r);
    int unsigned sx, sy, sz, bin, n, per_slice;
    int          d;
    logic [63:0] sq, q;
    sx = eff_extent(reg_sx);
    sy = eff_extent(reg_sy);
    sz = eff_extent(reg_sz);
    r = '0;
    case (c)
      CMD_SAMPLE: begin
        // pairs past the end of the volume are dropped and flagged
        if (at_z >= sz) begin
          overrun = 1'b1;
        end else begin
          d = int'($signed(a)) - int'($signed(b));
          if (d < 0) d = -d;
          sq = 64'(d) * 64'(d);
          case (live_axis())
            AXIS_Y: bin = at_y;
            AXIS_Z: bin = at_z;
            default: bin = at_x;
          endcase
          slice_sum[bin] = slice_sum[bin] + sq[SUM_W-1:0];
          // raster advance, wrapping against the current sizes
          if (at_x + 1 >= sx) begin
            at_x = 0;
            if (at_y + 1 >= sy) begin
              at_y = 0;
              at_z++;
            end else begin
              at_y++;
            end
          end else begin
            at_x++;
          end
        end
      end
      CMD_READ: begin
        n = slices_on_axis();
        case (live_axis())
          AXIS_Y: per_slice = sx * sz;
          AXIS_Z: per_slice = sx * sy;
          default: per_slice = sy * sz;
        endcase
        r.slice = si;
        if (int'(si) >= n) begin
          r.st = STAT_RANGE;
        end else begin
          q = {slice_sum[si], 16'b0} / 64'(per_slice);
          q = floor_sqrt(q);
          r.rmse = (q > 64'(RMSE_SAT)) ? RMSE_SAT : q[RMSE_W-1:0];
          r.st = overrun ? STAT_EXCESS : (at_z < sz) ? STAT_INCOMPLETE : STAT_OK;
        end
        return 1'b1;
      end
      CMD_CLEAR: clear_sums();
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void add_row(row_kind_t k, logic [1:0] op, logic [SAMPLE_W-1:0] a,
                                  logic [SAMPLE_W-1:0] b, logic [SIZE_W-1:0] arg,
                                  logic typed, logic [RMSE_W-1:0] rmse, status_t st);
    script_row_t row;
    row.kind = k;
    row.op = op;
    row.a = a;
    row.b = b;
    row.arg = arg;
    row.typed = typed;
    row.rmse = rmse;
    row.st = st;
    script.push_back(row);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_extent();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return SIZE_W'($urandom_range(1, 5));
    if (p < 75) return SIZE_W'($urandom_range(6, 16));
    if (p < 80) return '0;
    if (p < 87) return SIZE_W'(DEPTH);
    if (p < 93) return SIZE_W'($urandom_range(DEPTH + 1, SIZE_TOP));
    return SIZE_W'($urandom_range(17, DEPTH - 1));
  endfunction

  // mostly slices on the axis, sometimes anywhere in the index range
  function automatic logic [SLICE_W-1:0] pick_slice();
    if ($urandom_range(9) < 8) return SLICE_W'($urandom_range(slices_on_axis() - 1));
    return SLICE_W'($urandom);
  endfunction

  // present one item, hold until accepted, then predict it
  task automatic send_item(cmd_t c, logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                           logic [SLICE_W-1:0] si, bit typed, read_result_t typed_r);
    read_result_t r;
    start <= 1'b1;
    cmd <= c;
    sample_a <= a;
    sample_b <= b;
    slice_index <= si;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (step_slice_sums(c, a, b, si, r)) pending_reads.push_back(typed ? typed_r : r);
    if (c != CMD_NONE) items_sent++;
    // random gap after the item
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  // stop sending and wait until all reads are back and the block is quiet
  task automatic settle_block();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register write; valid is left high for a following write
  task automatic cfg_write(cfg_reg_t r, logic [SIZE_W-1:0] d);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_model_reg(r, d);
  endtask

  // one random volume: geometry, stream with noise and breaks, then reads
  task automatic random_volume();
    int unsigned         total, stream_len, n, p;
    logic [SAMPLE_W-1:0] a, b;
    read_result_t        none;
    none = '0;
    settle_block();
    cfg_write(REG_AXIS, SIZE_W'($urandom_range(SIZE_TOP)));
    cfg_write(REG_SIZE_X, pick_extent());
    cfg_write(REG_SIZE_Y, pick_extent());
    cfg_write(REG_SIZE_Z, pick_extent());
    cfg_valid <= 1'b0;
    if ($urandom_range(9) < 8) send_item(CMD_CLEAR, 16'($urandom), 16'($urandom),
                                         SLICE_W'($urandom), 1'b0, none);
    total = eff_extent(reg_sx) * eff_extent(reg_sy) * eff_extent(reg_sz);
    stream_len = (total < STREAM_CAP) ? total : STREAM_CAP;
    p = $urandom_range(99);
    if (p < 15) stream_len = $urandom_range(stream_len);
    else if (p < 30) stream_len += $urandom_range(1, 4);

    for (int i = 0; i < stream_len; i++) begin
      p = $urandom_range(199);
      if (p < 6) begin
        send_item(CMD_READ, 16'($urandom), 16'($urandom), pick_slice(), 1'b0, none);
      end else if (p < 8) begin
        send_item(CMD_NONE, 16'($urandom), 16'($urandom), SLICE_W'($urandom), 1'b0, none);
      end else if (p == 8) begin
        // resize in the middle of the stream
        settle_block();
        cfg_write(cfg_reg_t'($urandom_range(REG_SIZE_X, REG_SIZE_Z)), pick_extent());
        cfg_valid <= 1'b0;
      end else if (p == 9) begin
        settle_block();
      end
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(9))
        0: begin
          a = $urandom_range(1) ? S_MAX : S_MIN;
          b = $urandom_range(1) ? S_MAX : S_MIN;
        end
        1, 2, 3, 4: b = a + 16'($urandom_range(64)) - 16'd32;
        default: ;
      endcase
      send_item(CMD_SAMPLE, a, b, SLICE_W'($urandom), 1'b0, none);
    end

    // read back the slices
    n = slices_on_axis();
    if (n <= 8) begin
      for (int s = 0; s < n; s++)
        send_item(CMD_READ, 16'($urandom), 16'($urandom), SLICE_W'(s), 1'b0, none);
    end else begin
      repeat (6) send_item(CMD_READ, 16'($urandom), 16'($urandom), pick_slice(), 1'b0, none);
    end
    send_item(CMD_READ, 16'($urandom), 16'($urandom), SLICE_W'($urandom), 1'b0, none);
  endtask

  // compare each result with the oldest pending read
  always @(posedge clk) begin : result_check
    read_result_t want;
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: slice_number %0d, rmse_value %0d, status %0d",
               slice_number, rmse_value, status);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (rmse_value !== want.rmse) begin
          $error("rmse_value: expected %0d, got %0d", want.rmse, rmse_value);
          errors++;
        end
        if (slice_number !== want.slice) begin
          $error("slice_number: expected %0d, got %0d", want.slice, slice_number);
          errors++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    script_row_t  row;
    read_result_t want;
    int           random_goal;

    // directed table: after reset, extremes, range, excess, saturation, odd sizes
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b1, '0, STAT_INCOMPLETE);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd255, 1'b1, '0, STAT_INCOMPLETE);
    add_row(ROW_CFG, REG_AXIS, '0, '0, 9'(AXIS_X), 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_X, '0, '0, 9'd2, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Y, '0, '0, 9'd1, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Z, '0, '0, 9'd1, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MAX, S_MIN, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b1, RMSE_FULL, STAT_INCOMPLETE);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd2, 1'b1, '0, STAT_RANGE);
    add_row(ROW_CMD, CMD_SAMPLE, S_MIN, S_MAX, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd1, 1'b1, RMSE_FULL, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, 16'd5, 16'd5, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b1, RMSE_FULL, STAT_EXCESS);
    add_row(ROW_CMD, CMD_NONE, S_MAX, S_MIN, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd3, 1'b1, '0, STAT_RANGE);
    add_row(ROW_CMD, CMD_CLEAR, '0, '0, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b1, '0, STAT_INCOMPLETE);
    // four full-scale pairs into slice 0, then shrink y so the mean overflows
    add_row(ROW_CFG, REG_SIZE_X, '0, '0, 9'd1, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Y, '0, '0, 9'd4, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MAX, S_MIN, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MIN, S_MAX, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MAX, S_MIN, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MIN, S_MAX, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Y, '0, '0, 9'd1, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b1, RMSE_SAT, STAT_OK);
    // axis code 3, zero size and sizes above the depth
    add_row(ROW_CFG, REG_AXIS, '0, '0, 9'h1ff, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_X, '0, '0, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Y, '0, '0, 9'd300, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_SIZE_Z, '0, '0, 9'h1ff, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_CLEAR, '0, '0, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, 16'hffff, 16'h0000, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_SAMPLE, S_MIN, S_MIN, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd1, 1'b1, '0, STAT_RANGE);
    add_row(ROW_CFG, REG_AXIS, '0, '0, 9'(AXIS_Y), 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd1, 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b0, '0, STAT_OK);
    add_row(ROW_CFG, REG_AXIS, '0, '0, 9'(AXIS_Z), 1'b0, '0, STAT_OK);
    add_row(ROW_CMD, CMD_READ, '0, '0, 9'd0, 1'b0, '0, STAT_OK);

    // model state after reset
    clear_sums();
    reg_axis = AXIS_X;
    reg_sx = SIZE_W'(DEPTH);
    reg_sy = SIZE_W'(DEPTH);
    reg_sz = SIZE_W'(DEPTH);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // wait out the clearing sweep
    settle_block();

    // directed part
    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        settle_block();
        cfg_write(cfg_reg_t'(row.op), row.arg);
        cfg_valid <= 1'b0;
      end else begin
        want.rmse = row.rmse;
        want.slice = row.arg[SLICE_W-1:0];
        want.st = row.st;
        send_item(cmd_t'(row.op), row.a, row.b, row.arg[SLICE_W-1:0], row.typed, want);
      end
    end

    // random part, with a stretch of back-to-back items in the middle
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      idle_on = !(items_sent >= random_goal - 1000 && items_sent < random_goal - 600);
      random_volume();
    end

    settle_block();
    repeat (TAIL) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
